### sv/telt_pkg.sv
`default_nettype none

package telt_pkg;

    localparam int TIME_BITS  = 32;
    localparam int SCORE_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COOLDOWN         = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DURATION     = 2'd2;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_REFRACTORY,
        EV_OPENED,
        EV_HELD,
        EV_ACCEPTED,
        EV_REJECTED
    } telt_status_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]         timestamp_ms;
        logic                         present;
        logic                         attack_ok;
        logic                         attack_score_ok;
        logic                         release_ok;
        logic                         release_score_ok;
        logic [SCORE_BITS-1:0]        band_score;
        logic signed [SCORE_BITS-1:0] band_contrast;
    } telt_sample_t;

    typedef struct packed {
        telt_status_t                 status;
        logic [TIME_BITS-1:0]         duration_ms;
        logic [TIME_BITS-1:0]         open_time_ms;
        logic [TIME_BITS-1:0]         peak_time_ms;
        logic [SCORE_BITS-1:0]        peak_score;
        logic signed [SCORE_BITS-1:0] peak_contrast;
        logic [TIME_BITS-1:0]         attack_cover_ms;
        logic [TIME_BITS-1:0]         release_cover_ms;
        logic [COUNT_BITS-1:0]        island_total;
        logic [COUNT_BITS-1:0]        gap_total;
        logic [TIME_BITS-1:0]         island_longest_ms;
        logic [TIME_BITS-1:0]         gap_longest_ms;
    } telt_report_t;

endpackage

`default_nettype wire

### sv/tone_event_lifecycle_tracker_core.sv
// Tone event lifecycle tracker.
// Sample channel (sample_valid/sample_ready/sample): one timestamped band
// measurement with its upstream attack and release gate flags per item.
// Report channel (report_valid/report_ready/report): exactly one report per
// sample, carrying the event status and the statistics of the current or
// last event as they stand after that sample.
// Configuration: cfg_write with cfg_index and cfg_data writes the release
// debounce, cooldown or minimum duration register in the same edge; write
// only while no report is pending.
// The report is valid in the cycle after the sample is taken. One item is
// taken per cycle while the receiver keeps up, set by the single pass of compare
// and add logic from the sample port into the state and report registers.
// A new sample is taken while the held report is being taken in the same cycle.
// When the receiver stalls, the report holds and sample_ready drops until the
// report is taken.
// Reset clears all event state, the configuration registers and any pending
// report.
`default_nettype none

module tone_event_lifecycle_tracker_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    input  wire telt_pkg::telt_sample_t               sample,
    output logic                                      report_valid,
    input  wire logic                                 report_ready,
    output telt_pkg::telt_report_t                    report,
    input  wire logic                                 cfg_write,
    input  wire logic [telt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [telt_pkg::CFG_BITS-1:0]        cfg_data
);
    import telt_pkg::*;

    localparam logic [TIME_BITS-1:0]  TIME_ZERO = '0;
    localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] span_max(
        input logic [TIME_BITS-1:0] now,
        input logic [TIME_BITS-1:0] start,
        input logic [TIME_BITS-1:0] longest
    );
        logic [TIME_BITS-1:0] span;
        span = now - start;
        if (start != TIME_ZERO && now >= start && span > longest)
        begin
            return span;
        end
        return longest;
    endfunction

    function automatic logic [TIME_BITS-1:0] fwd_diff(
        input logic [TIME_BITS-1:0] now,
        input logic [TIME_BITS-1:0] start
    );
        return (now >= start) ? now - start : TIME_ZERO;
    endfunction

    logic [CFG_BITS-1:0] debounce_reg;
    logic [CFG_BITS-1:0] cooldown_reg;
    logic [CFG_BITS-1:0] min_duration_reg;

    logic                         active_reg, active_next;
    logic                         was_above_reg, was_above_next;
    logic [TIME_BITS-1:0]         refractory_until_reg, refractory_until_next;
    logic [TIME_BITS-1:0]         open_time_reg, open_time_next;
    logic [TIME_BITS-1:0]         last_match_reg, last_match_next;
    logic [TIME_BITS-1:0]         duration_reg, duration_next;
    logic [SCORE_BITS-1:0]        peak_value_reg, peak_value_next;
    logic signed [SCORE_BITS-1:0] peak_contrast_reg, peak_contrast_next;
    logic [TIME_BITS-1:0]         peak_time_reg, peak_time_next;
    logic [TIME_BITS-1:0]         attack_cover_reg, attack_cover_next;
    logic [TIME_BITS-1:0]         release_cover_reg, release_cover_next;
    logic [COUNT_BITS-1:0]        island_count_reg, island_count_next;
    logic [COUNT_BITS-1:0]        gap_count_reg, gap_count_next;
    logic [TIME_BITS-1:0]         island_max_reg, island_max_next;
    logic [TIME_BITS-1:0]         gap_max_reg, gap_max_next;
    logic [TIME_BITS-1:0]         island_start_reg, island_start_next;
    logic [TIME_BITS-1:0]         gap_start_reg, gap_start_next;
    logic [TIME_BITS-1:0]         last_update_reg, last_update_next;

    logic                 report_valid_reg;
    telt_report_t         report_reg, report_next;
    telt_status_t         status;
    logic                 accept;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] refr_diff;
    logic [TIME_BITS-1:0] delta;
    logic                 blocked;
    logic                 open_now;
    logic                 debounce_done;
    logic                 close_now;

    assign sample_ready = !report_valid_reg || report_ready;
    assign accept       = sample_valid && sample_ready;
    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    assign now       = sample.timestamp_ms;
    assign refr_diff = now - refractory_until_reg;
    assign blocked   = refr_diff[TIME_BITS-1];
    assign open_now  = sample.present && !active_reg && sample.attack_ok && !blocked;
    assign debounce_done = (last_match_reg != TIME_ZERO) &&
        ((now - last_match_reg) >= {{(TIME_BITS-CFG_BITS){1'b0}}, debounce_reg});
    assign close_now = active_reg && debounce_done &&
        (!sample.present || !sample.release_ok);

    always_comb
    begin
        active_next           = active_reg;
        was_above_next        = was_above_reg;
        refractory_until_next = refractory_until_reg;
        open_time_next        = open_time_reg;
        last_match_next       = last_match_reg;
        duration_next         = duration_reg;
        peak_value_next       = peak_value_reg;
        peak_contrast_next    = peak_contrast_reg;
        peak_time_next        = peak_time_reg;
        attack_cover_next     = attack_cover_reg;
        release_cover_next    = release_cover_reg;
        island_count_next     = island_count_reg;
        gap_count_next        = gap_count_reg;
        island_max_next       = island_max_reg;
        gap_max_next          = gap_max_reg;
        island_start_next     = island_start_reg;
        gap_start_next        = gap_start_reg;
        last_update_next      = last_update_reg;
        delta                 = TIME_ZERO;
        status                = EV_IDLE;

        if (sample.present && !active_reg && sample.attack_ok && blocked)
        begin
            status = EV_REFRACTORY;
        end

        if (open_now)
        begin
            active_next        = 1'b1;
            open_time_next     = now;
            peak_time_next     = now;
            last_match_next    = now;
            duration_next      = TIME_ZERO;
            peak_value_next    = sample.band_score;
            peak_contrast_next = sample.band_contrast;
            attack_cover_next  = TIME_ZERO;
            release_cover_next = TIME_ZERO;
            gap_count_next     = '0;
            island_max_next    = TIME_ZERO;
            gap_max_next       = TIME_ZERO;
            gap_start_next     = TIME_ZERO;
            was_above_next     = 1'b1;
            island_count_next  = COUNT_BITS'(1);
            island_start_next  = now;
            last_update_next   = now;
            status             = EV_OPENED;
        end

        // coverage and island/gap tracking
        if (open_now || (sample.present && active_reg))
        begin
            delta = (last_update_next == TIME_ZERO) ? TIME_ZERO
                                                    : fwd_diff(now, last_update_next);
            if (sample.attack_score_ok)
            begin
                attack_cover_next = sat_add(attack_cover_next, delta);
            end
            if (sample.release_score_ok)
            begin
                release_cover_next = sat_add(release_cover_next, delta);
                if (!was_above_next)
                begin
                    if (island_count_next != COUNT_MAX)
                    begin
                        island_count_next = island_count_next + COUNT_BITS'(1);
                    end
                    gap_max_next      = span_max(now, gap_start_next, gap_max_next);
                    island_start_next = now;
                    gap_start_next    = TIME_ZERO;
                end
            end
            else if (was_above_next)
            begin
                if (gap_count_next != COUNT_MAX)
                begin
                    gap_count_next = gap_count_next + COUNT_BITS'(1);
                end
                island_max_next   = span_max(now, island_start_next, island_max_next);
                gap_start_next    = now;
                island_start_next = TIME_ZERO;
            end
            was_above_next   = sample.release_score_ok;
            last_update_next = now;
        end

        if (active_reg)
        begin
            status = EV_HELD;
        end

        if (sample.present && active_reg && sample.release_ok)
        begin
            last_match_next = now;
            duration_next   = fwd_diff(now, open_time_reg);
            if (sample.band_score > peak_value_reg ||
                (sample.band_score == peak_value_reg &&
                 sample.band_contrast > peak_contrast_reg))
            begin
                peak_time_next     = now;
                peak_value_next    = sample.band_score;
                peak_contrast_next = sample.band_contrast;
            end
        end

        if (close_now)
        begin
            if (was_above_next)
            begin
                island_max_next = span_max(now, island_start_next, island_max_next);
            end
            else
            begin
                gap_max_next = span_max(now, gap_start_next, gap_max_next);
            end
            active_next           = 1'b0;
            duration_next         = fwd_diff(now, open_time_reg);
            refractory_until_next = now + {{(TIME_BITS-CFG_BITS){1'b0}}, cooldown_reg};
            status = (duration_next >= {{(TIME_BITS-CFG_BITS){1'b0}}, min_duration_reg})
                   ? EV_ACCEPTED : EV_REJECTED;
        end
    end

    always_comb
    begin
        report_next.status            = status;
        report_next.duration_ms       = duration_next;
        report_next.open_time_ms      = open_time_next;
        report_next.peak_time_ms      = peak_time_next;
        report_next.peak_score        = peak_value_next;
        report_next.peak_contrast     = peak_contrast_next;
        report_next.attack_cover_ms   = attack_cover_next;
        report_next.release_cover_ms  = release_cover_next;
        report_next.island_total      = island_count_next;
        report_next.gap_total         = gap_count_next;
        report_next.island_longest_ms = island_max_next;
        report_next.gap_longest_ms    = gap_max_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= '0;
            cooldown_reg     <= '0;
            min_duration_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RELEASE_DEBOUNCE: debounce_reg     <= cfg_data;
                CFG_COOLDOWN:         cooldown_reg     <= cfg_data;
                CFG_MIN_DURATION:     min_duration_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg           <= 1'b0;
            was_above_reg        <= 1'b0;
            refractory_until_reg <= '0;
            open_time_reg        <= '0;
            last_match_reg       <= '0;
            duration_reg         <= '0;
            peak_value_reg       <= '0;
            peak_contrast_reg    <= '0;
            peak_time_reg        <= '0;
            attack_cover_reg     <= '0;
            release_cover_reg    <= '0;
            island_count_reg     <= '0;
            gap_count_reg        <= '0;
            island_max_reg       <= '0;
            gap_max_reg          <= '0;
            island_start_reg     <= '0;
            gap_start_reg        <= '0;
            last_update_reg      <= '0;
        end
        else if (accept)
        begin
            active_reg           <= active_next;
            was_above_reg        <= was_above_next;
            refractory_until_reg <= refractory_until_next;
            open_time_reg        <= open_time_next;
            last_match_reg       <= last_match_next;
            duration_reg         <= duration_next;
            peak_value_reg       <= peak_value_next;
            peak_contrast_reg    <= peak_contrast_next;
            peak_time_reg        <= peak_time_next;
            attack_cover_reg     <= attack_cover_next;
            release_cover_reg    <= release_cover_next;
            island_count_reg     <= island_count_next;
            gap_count_reg        <= gap_count_next;
            island_max_reg       <= island_max_next;
            gap_max_reg          <= gap_max_next;
            island_start_reg     <= island_start_next;
            gap_start_reg        <= gap_start_next;
            last_update_reg      <= last_update_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            report_valid_reg <= 1'b1;
        end
        else if (report_ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            report_reg <= report_next;
        end
    end

    a_accept_gives_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> report_valid)
        else $error("accepted item produced no report");

    a_status_matches_active: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> (active_reg ==
            (report_reg.status == EV_OPENED || report_reg.status == EV_HELD)))
        else $error("report status disagrees with event state");

    a_open_has_island: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (island_count_reg != '0))
        else $error("open event with zero islands");

    a_above_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        was_above_reg |-> (gap_start_reg == '0))
        else $error("gap running while above release");

    a_below_no_island: assert property (@(posedge clk) disable iff (!rst_n)
        !was_above_reg |-> (island_start_reg == '0))
        else $error("island running while below release");

endmodule

`default_nettype wire
